/* rtl/hmbd_pkg.sv */
// shared types, address map constants and command codes for the memory bus decoder
`default_nettype none

package hmbd_pkg;

    localparam int BOOT_BYTES = 256;
    localparam int BOOT_AW    = $clog2(BOOT_BYTES);
    localparam int MAIN_AW    = 16;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;
    localparam logic [1:0] CMD_BOOT  = 2'd3;

    localparam logic [1:0] TGT_LOCAL = 2'd0;
    localparam logic [1:0] TGT_VIDEO = 2'd1;
    localparam logic [1:0] TGT_TIMER = 2'd2;

    localparam logic [15:0] ADDR_ROM_TOP  = 16'h7FFF;
    localparam logic [15:0] ADDR_WRAM_LO  = 16'hC000;
    localparam logic [15:0] ADDR_WRAM_HI  = 16'hDDFF;
    localparam logic [15:0] ADDR_ECHO_LO  = 16'hE000;
    localparam logic [15:0] ADDR_ECHO_HI  = 16'hFDFF;
    localparam logic [15:0] ECHO_OFFSET   = 16'h2000;
    localparam logic [15:0] ADDR_JOYP     = 16'hFF00;
    localparam logic [15:0] ADDR_SB       = 16'hFF01;
    localparam logic [15:0] ADDR_SC       = 16'hFF02;
    localparam logic [15:0] ADDR_DIV      = 16'hFF04;
    localparam logic [15:0] ADDR_TAC      = 16'hFF07;
    localparam logic [15:0] ADDR_IF       = 16'hFF0F;
    localparam logic [15:0] ADDR_LCDC     = 16'hFF40;
    localparam logic [15:0] ADDR_STAT     = 16'hFF41;
    localparam logic [15:0] ADDR_LY       = 16'hFF44;
    localparam logic [15:0] ADDR_DMA      = 16'hFF46;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [15:0] ADDR_IE       = 16'hFFFF;

    localparam logic [7:0] JOY_FIXED     = 8'hCF;
    localparam logic [7:0] JOY_SEL_MASK  = 8'h30;
    localparam logic [7:0] IF_READ_ONES  = 8'hE0;
    localparam logic [7:0] IF_JOYPAD     = 8'h10;
    localparam logic [7:0] SERIAL_START  = 8'h81;
    localparam logic [7:0] SERIAL_KEEP   = 8'h7F;
    localparam logic [7:0] LOCKOUT_DATA  = 8'hFF;

    typedef struct packed {
        logic below_io;
        logic rom;
        logic boot_range;
        logic joyp;
        logic boot_off;
        logic video;
        logic timer;
        logic iflag;
        logic ie;
        logic serial_ctl;
        logic dma_reg;
        logic echo_lo;
        logic echo_hi;
    } t_dec;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] target;
        logic       target_write;
        logic       serial_valid;
        logic [7:0] serial_byte;
        logic       dma_start;
        logic [7:0] dma_page;
    } t_res;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [MAIN_AW-1:0] addr;
        logic [7:0]         wdata;
    } t_main_req;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [BOOT_AW-1:0] addr;
        logic [7:0]         wdata;
    } t_boot_req;

endpackage

`default_nettype wire

/* rtl/hmbd_if.sv */
// valid/ready channel interfaces for bus accesses and their results
`default_nettype none

interface hmbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  keys;
    logic        dma_done;

    modport source (output valid, command, address, write_data, keys, dma_done,
                    input ready);
    modport sink   (input valid, command, address, write_data, keys, dma_done,
                    output ready);
endinterface

interface hmbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [1:0]  target;
    logic        target_write;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        dma_start;
    logic [7:0]  dma_page;

    modport source (output valid, read_data, target, target_write, serial_valid,
                    serial_byte, dma_start, dma_page, input ready);
    modport sink   (input valid, read_data, target, target_write, serial_valid,
                    serial_byte, dma_start, dma_page, output ready);
endinterface

`default_nettype wire

/* rtl/handheld_memory_bus_decoder_top.sv */
// top level of the handheld memory bus decoder: sequencer, byte stores and result register
//
//  channel  dir  handshake      payload
//  i_req    in   valid / ready  command, address, write_data, keys, dma_done
//  o_rsp    out  valid / ready  read_data, target, target_write, serial_valid,
//                               serial_byte, dma_start, dma_page
//
// an access is sequenced over the single port of the 64 KiB store, so joypad
// sampling and echo writes need extra store accesses
// synchronous active-low reset; the stores are not cleared and need no clearing pass
// a result waits in the output register while the next access is taken in;
// the sequencer holds its finished result until that register is free
`default_nettype none

module handheld_memory_bus_decoder_top
    import hmbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hmbd_req_if.sink  i_req,
    hmbd_rsp_if.source o_rsp
);

    t_main_req  main_req;
    t_boot_req  boot_req;
    logic [7:0] main_q;
    logic [7:0] boot_q;
    logic       res_valid;
    logic       res_ready;
    t_res       res;

    logic       r_out_valid;
    t_res       r_out;

    hmbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_main      (main_req),
        .i_main_q    (main_q),
        .o_boot      (boot_req),
        .i_boot_q    (boot_q),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    hmbd_ram #(
        .ADDR_W (MAIN_AW),
        .DATA_W (8)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_req.we),
        .i_re    (main_req.re),
        .i_addr  (main_req.addr),
        .i_wdata (main_req.wdata),
        .o_rdata (main_q)
    );

    hmbd_ram #(
        .ADDR_W (BOOT_AW),
        .DATA_W (8)
    ) u_boot_ram (
        .i_clk   (i_clk),
        .i_we    (boot_req.we),
        .i_re    (boot_req.re),
        .i_addr  (boot_req.addr),
        .i_wdata (boot_req.wdata),
        .o_rdata (boot_q)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out.read_data;
    assign o_rsp.target       = r_out.target;
    assign o_rsp.target_write = r_out.target_write;
    assign o_rsp.serial_valid = r_out.serial_valid;
    assign o_rsp.serial_byte  = r_out.serial_byte;
    assign o_rsp.dma_start    = r_out.dma_start;
    assign o_rsp.dma_page     = r_out.dma_page;

endmodule

`default_nettype wire

/* rtl/hmbd_ram.sv */
// generic single-port synchronous ram with registered read data
`default_nettype none

module hmbd_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

/* rtl/hmbd_dec.sv */
// address map decoder for the bus
`default_nettype none

module hmbd_dec
    import hmbd_pkg::*;
(
    input  wire logic [15:0] i_addr,
    output t_dec             o_dec
);

    always_comb begin
        o_dec.below_io   = i_addr < ADDR_JOYP;
        o_dec.rom        = i_addr <= ADDR_ROM_TOP;
        o_dec.boot_range = i_addr < 16'(BOOT_BYTES);
        o_dec.joyp       = i_addr == ADDR_JOYP;
        o_dec.boot_off   = i_addr == ADDR_BOOT_OFF;
        o_dec.video      = i_addr inside {ADDR_LCDC, ADDR_STAT, ADDR_LY};
        o_dec.timer      = i_addr inside {[ADDR_DIV:ADDR_TAC]};
        o_dec.iflag      = i_addr == ADDR_IF;
        o_dec.ie         = i_addr == ADDR_IE;
        o_dec.serial_ctl = i_addr == ADDR_SC;
        o_dec.dma_reg    = i_addr == ADDR_DMA;
        o_dec.echo_lo    = i_addr inside {[ADDR_WRAM_LO:ADDR_WRAM_HI]};
        o_dec.echo_hi    = i_addr inside {[ADDR_ECHO_LO:ADDR_ECHO_HI]};
    end

endmodule

`default_nettype wire

/* rtl/hmbd_ctrl.sv */
// access sequencer: read-modify-write of the byte stores and the bus registers
`default_nettype none

module hmbd_ctrl
    import hmbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    hmbd_req_if.sink       i_req,
    output t_main_req      o_main,
    input  wire logic [7:0] i_main_q,
    output t_boot_req      o_boot,
    input  wire logic [7:0] i_boot_q,
    output logic           o_res_valid,
    input  wire logic      i_res_ready,
    output t_res           o_res
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_RD_WAIT = 4'd2;
    localparam logic [3:0] S_JOY     = 4'd3;
    localparam logic [3:0] S_IF_RD   = 4'd4;
    localparam logic [3:0] S_IF_WR   = 4'd5;
    localparam logic [3:0] S_SER     = 4'd6;
    localparam logic [3:0] S_WR2     = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]  r_state, n_state;
    logic        r_boot_mapped, n_boot_mapped;
    logic [7:0]  r_ie, n_ie;
    logic        r_dma, n_dma;
    t_res        r_res, n_res;

    logic [1:0]  r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic [7:0]  r_keys;

    t_dec        dec;
    logic        accept;
    logic [7:0]  joy_before;
    logic [7:0]  joy_now;

    hmbd_dec u_dec (
        .i_addr (r_addr),
        .o_dec  (dec)
    );

    // joypad line merge
    function automatic logic [7:0] joy_sample(input logic [7:0] prev,
                                              input logic [7:0] keys);
        logic [7:0] now;
        logic [3:0] pull;
        now  = prev | 8'h0F;
        pull = 4'h0;
        if (!now[5]) begin
            pull = pull | keys[3:0];
        end
        if (!now[4]) begin
            pull = pull | {keys[5], keys[4], keys[6], keys[7]};
        end
        return {now[7:4], now[3:0] & ~pull};
    endfunction

    function automatic logic joy_fall(input logic [7:0] prev, input logic [7:0] now);
        return |(prev[3:0] & ~now[3:0]);
    endfunction

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign joy_before  = (r_state == S_JOY) ? i_main_q : (JOY_FIXED | (r_wdata & JOY_SEL_MASK));
    assign joy_now     = joy_sample(joy_before, r_keys);

    always_comb begin
        n_state       = r_state;
        n_boot_mapped = r_boot_mapped;
        n_ie          = r_ie;
        n_dma         = r_dma;
        n_res         = r_res;
        o_main        = '0;
        o_boot        = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res   = '0;
                    n_dma   = r_dma && !i_req.dma_done;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_LOAD: begin
                        o_main.we    = 1'b1;
                        o_main.addr  = r_addr;
                        o_main.wdata = r_wdata;
                    end
                    CMD_BOOT: begin
                        if (dec.boot_range) begin
                            o_boot.we    = 1'b1;
                            o_boot.addr  = r_addr[BOOT_AW-1:0];
                            o_boot.wdata = r_wdata;
                        end
                    end
                    CMD_READ: begin
                        if (r_dma && dec.below_io) begin
                            n_res.read_data = LOCKOUT_DATA;
                        end else if (dec.joyp) begin
                            o_main.re   = 1'b1;
                            o_main.addr = ADDR_JOYP;
                            n_state     = S_JOY;
                        end else if (dec.boot_range && r_boot_mapped) begin
                            o_boot.re   = 1'b1;
                            o_boot.addr = r_addr[BOOT_AW-1:0];
                            n_state     = S_RD_WAIT;
                        end else if (dec.video) begin
                            n_res.target = TGT_VIDEO;
                        end else if (dec.timer) begin
                            n_res.target = TGT_TIMER;
                        end else if (dec.ie) begin
                            n_res.read_data = r_ie;
                        end else begin
                            o_main.re   = 1'b1;
                            o_main.addr = r_addr;
                            n_state     = S_RD_WAIT;
                        end
                    end
                    default: begin
                        if ((r_dma && dec.below_io) || dec.rom) begin
                            n_state = S_DONE;
                        end else if (dec.joyp) begin
                            o_main.we    = 1'b1;
                            o_main.addr  = ADDR_JOYP;
                            o_main.wdata = joy_now;
                            if (joy_fall(joy_before, joy_now)) begin
                                n_state = S_IF_RD;
                            end
                        end else if (dec.boot_off) begin
                            n_boot_mapped = 1'b0;
                        end else if (dec.video) begin
                            n_res.target       = TGT_VIDEO;
                            n_res.target_write = 1'b1;
                        end else if (dec.timer) begin
                            n_res.target       = TGT_TIMER;
                            n_res.target_write = 1'b1;
                        end else if (dec.ie) begin
                            n_ie = r_wdata;
                        end else if (dec.serial_ctl && r_wdata == SERIAL_START) begin
                            o_main.re   = 1'b1;
                            o_main.addr = ADDR_SB;
                            n_state     = S_SER;
                        end else if (dec.echo_lo) begin
                            o_main.we    = 1'b1;
                            o_main.addr  = r_addr + ECHO_OFFSET;
                            o_main.wdata = r_wdata;
                            n_state      = S_WR2;
                        end else if (dec.echo_hi) begin
                            o_main.we    = 1'b1;
                            o_main.addr  = r_addr - ECHO_OFFSET;
                            o_main.wdata = r_wdata;
                            n_state      = S_WR2;
                        end else begin
                            o_main.we    = 1'b1;
                            o_main.addr  = r_addr;
                            o_main.wdata = r_wdata;
                            if (dec.dma_reg) begin
                                n_dma           = 1'b1;
                                n_res.dma_start = 1'b1;
                                n_res.dma_page  = r_wdata;
                            end
                        end
                    end
                endcase
            end
            S_RD_WAIT: begin
                if (dec.boot_range && r_boot_mapped) begin
                    n_res.read_data = i_boot_q;
                end else if (dec.iflag) begin
                    n_res.read_data = i_main_q | IF_READ_ONES;
                end else begin
                    n_res.read_data = i_main_q;
                end
                n_state = S_DONE;
            end
            S_JOY: begin
                o_main.we       = 1'b1;
                o_main.addr     = ADDR_JOYP;
                o_main.wdata    = joy_now;
                n_res.read_data = joy_now;
                n_state         = joy_fall(joy_before, joy_now) ? S_IF_RD : S_DONE;
            end
            S_IF_RD: begin
                o_main.re   = 1'b1;
                o_main.addr = ADDR_IF;
                n_state     = S_IF_WR;
            end
            S_IF_WR: begin
                o_main.we    = 1'b1;
                o_main.addr  = ADDR_IF;
                o_main.wdata = i_main_q | IF_JOYPAD;
                n_state      = S_DONE;
            end
            S_SER: begin
                n_res.serial_valid = 1'b1;
                n_res.serial_byte  = i_main_q;
                o_main.we          = 1'b1;
                o_main.addr        = ADDR_SC;
                o_main.wdata       = r_wdata & SERIAL_KEEP;
                n_state            = S_DONE;
            end
            S_WR2: begin
                o_main.we    = 1'b1;
                o_main.addr  = r_addr;
                o_main.wdata = r_wdata;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_boot_mapped <= 1'b1;
            r_ie          <= 8'h00;
            r_dma         <= 1'b0;
            r_res         <= '0;
        end else begin
            r_state       <= n_state;
            r_boot_mapped <= n_boot_mapped;
            r_ie          <= n_ie;
            r_dma         <= n_dma;
            r_res         <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_req.command;
            r_addr  <= i_req.address;
            r_wdata <= i_req.write_data;
            r_keys  <= i_req.keys;
        end
    end

endmodule

`default_nettype wire

/* tb/handheld_memory_bus_decoder_top_tb.sv */
// testbench for the memory bus decoder: directed and random bus accesses checked against a behavioural scoreboard
`timescale 1ns / 1ps

import hmbd_pkg::*;

class bus_scoreboard;
    logic [7:0]  main_copy [65536];
    bit          main_written [65536];
    logic [7:0]  boot_copy [BOOT_BYTES];
    bit          boot_written [BOOT_BYTES];
    bit          boot_on;
    logic [7:0]  ie_copy;
    bit          dma_busy;
    t_res        owed_results [$];
    logic [15:0] recent_addrs [$];
    int          errors;
    int          n_checked, n_read, n_locked, n_write, n_load, n_boot;
    int          n_fwd, n_serial, n_dma, n_joy_irq;

    function new();
        boot_on  = 1'b1;
        ie_copy  = '0;
        dma_busy = 1'b0;
        errors   = 0;
    endfunction

    function void put(logic [15:0] addr, logic [7:0] v);
        main_copy[addr]    = v;
        main_written[addr] = 1'b1;
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > 48) void'(recent_addrs.pop_front());
    endfunction

    function bit is_video(logic [15:0] addr);
        return addr == ADDR_LCDC || addr == ADDR_STAT || addr == ADDR_LY;
    endfunction

    function bit is_timer(logic [15:0] addr);
        return addr >= ADDR_DIV && addr <= ADDR_TAC;
    endfunction

    function void sample_joypad(logic [7:0] keys);
        logic [7:0] was, now, pull;
        was  = main_copy[ADDR_JOYP];
        now  = was | 8'h0F;
        pull = '0;
        if (!now[5]) pull[3:0] = keys[3:0];
        if (!now[4]) begin
            pull[0] = pull[0] | keys[7];
            pull[1] = pull[1] | keys[6];
            pull[2] = pull[2] | keys[4];
            pull[3] = pull[3] | keys[5];
        end
        now = now & ~pull;
        main_copy[ADDR_JOYP] = now;
        if ((was & ~now & 8'h0F) != 0) begin
            main_copy[ADDR_IF] = main_copy[ADDR_IF] | IF_JOYPAD;
            n_joy_irq++;
        end
    endfunction

    // turns an access that would read a never-written entry into a load or boot load at its own address
    function logic [1:0] safe_command(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wdata,
                                      logic done);
        bit locked;
        locked = dma_busy && !done && addr < ADDR_JOYP;
        if (locked) return cmd;
        if (cmd == CMD_READ) begin
            if (addr < BOOT_BYTES && boot_on)
                return boot_written[addr[BOOT_AW-1:0]] ? cmd : CMD_BOOT;
            if (is_video(addr) || is_timer(addr) || addr == ADDR_IE) return cmd;
            if (addr == ADDR_JOYP)
                return (main_written[ADDR_JOYP] && main_written[ADDR_IF]) ? cmd : CMD_LOAD;
            return main_written[addr] ? cmd : CMD_LOAD;
        end
        if (cmd == CMD_WRITE) begin
            if (addr == ADDR_JOYP && !main_written[ADDR_IF]) return CMD_LOAD;
            if (addr == ADDR_SC && wdata == SERIAL_START && !main_written[ADDR_SB])
                return CMD_LOAD;
        end
        return cmd;
    endfunction

    function void note_access(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wdata,
                              logic [7:0] keys, logic done);
        t_res       r;
        logic [7:0] v;
        r = '0;
        v = wdata;
        if (done) dma_busy = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                n_load++;
                put(addr, v);
            end
            CMD_BOOT: begin
                n_boot++;
                if (addr < BOOT_BYTES) begin
                    boot_copy[addr[BOOT_AW-1:0]]    = v;
                    boot_written[addr[BOOT_AW-1:0]] = 1'b1;
                end
            end
            CMD_READ: begin
                n_read++;
                if (dma_busy && addr < ADDR_JOYP) begin
                    r.read_data = LOCKOUT_DATA;
                    n_locked++;
                end else begin
                    if (addr == ADDR_JOYP) sample_joypad(keys);
                    if (addr < BOOT_BYTES && boot_on) r.read_data = boot_copy[addr[BOOT_AW-1:0]];
                    else if (is_video(addr)) r.target = TGT_VIDEO;
                    else if (is_timer(addr)) r.target = TGT_TIMER;
                    else if (addr == ADDR_IF) r.read_data = main_copy[addr] | IF_READ_ONES;
                    else if (addr == ADDR_IE) r.read_data = ie_copy;
                    else r.read_data = main_copy[addr];
                end
            end
            default: begin
                n_write++;
                if (dma_busy && addr < ADDR_JOYP) begin
                    n_locked++;
                end else if (addr <= ADDR_ROM_TOP) begin
                end else if (addr == ADDR_JOYP) begin
                    put(addr, JOY_FIXED | (v & JOY_SEL_MASK));
                    sample_joypad(keys);
                end else if (addr == ADDR_BOOT_OFF) begin
                    boot_on = 1'b0;
                end else if (is_video(addr)) begin
                    r.target       = TGT_VIDEO;
                    r.target_write = 1'b1;
                end else if (is_timer(addr)) begin
                    r.target       = TGT_TIMER;
                    r.target_write = 1'b1;
                end else if (addr == ADDR_IE) begin
                    ie_copy = v;
                end else begin
                    if (addr == ADDR_SC && v == SERIAL_START) begin
                        r.serial_valid = 1'b1;
                        r.serial_byte  = main_copy[ADDR_SB];
                        v = v & SERIAL_KEEP;
                        n_serial++;
                    end
                    if (addr >= ADDR_WRAM_LO && addr <= ADDR_WRAM_HI) put(addr + ECHO_OFFSET, v);
                    if (addr >= ADDR_ECHO_LO && addr <= ADDR_ECHO_HI) put(addr - ECHO_OFFSET, v);
                    if (addr == ADDR_DMA) begin
                        dma_busy    = 1'b1;
                        r.dma_start = 1'b1;
                        r.dma_page  = v;
                        n_dma++;
                    end
                    put(addr, v);
                end
            end
        endcase
        if (r.target != TGT_LOCAL) n_fwd++;
        owed_results.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_res got);
        t_res want;
        if (owed_results.size() == 0) begin
            $display("%0t unexpected result: actual %0h", $time, got);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        n_checked++;
        check_field("read_data", want.read_data, got.read_data);
        check_field("target", 8'(want.target), 8'(got.target));
        check_field("target_write", 8'(want.target_write), 8'(got.target_write));
        check_field("serial_valid", 8'(want.serial_valid), 8'(got.serial_valid));
        check_field("serial_byte", want.serial_byte, got.serial_byte);
        check_field("dma_start", 8'(want.dma_start), 8'(got.dma_start));
        check_field("dma_page", want.dma_page, got.dma_page);
    endfunction
endclass

module handheld_memory_bus_decoder_top_tb;
    import hmbd_pkg::*;

    localparam int RANDOM_ITEMS = 1300;

    logic i_clk;
    logic i_rst_n;

    hmbd_req_if req_ch ();
    hmbd_rsp_if rsp_ch ();

    handheld_memory_bus_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bus_scoreboard sb = new();

    int   burst_left = 0;
    int   hold_left  = 0;
    t_res seen;

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", sb.owed_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // receiver: long hold-off on request, else a changing ready pattern
    initial begin
        int         pat_mode;
        int         pat_left;
        logic [31:0] pat_bits;
        pat_mode = 0;
        pat_left = 0;
        pat_bits = '1;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(20, 120);
                    pat_bits = $urandom;
                end
                pat_left--;
                case (pat_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= pat_bits[pat_left % 32];
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            seen.read_data    = rsp_ch.read_data;
            seen.target       = rsp_ch.target;
            seen.target_write = rsp_ch.target_write;
            seen.serial_valid = rsp_ch.serial_valid;
            seen.serial_byte  = rsp_ch.serial_byte;
            seen.dma_start    = rsp_ch.dma_start;
            seen.dma_page     = rsp_ch.dma_page;
            sb.check_result(seen);
        end
    end

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 11))
            0: return 16'($urandom_range(0, BOOT_BYTES - 1));
            1: return 16'($urandom_range(0, ADDR_ROM_TOP));
            2: return 16'($urandom_range(ADDR_WRAM_LO, ADDR_WRAM_HI));
            3: return 16'($urandom_range(ADDR_ECHO_LO, ADDR_ECHO_HI));
            4: return 16'($urandom_range(ADDR_JOYP, ADDR_JOYP + 16'h7F));
            5: return 16'($urandom_range(16'hFF80, ADDR_IE));
            6: return 16'($urandom);
            7: return 16'($urandom_range(ADDR_WRAM_HI + 1, ADDR_ECHO_LO - 1));
            default: begin
                case ($urandom_range(0, 15))
                    0:  return ADDR_JOYP;
                    1:  return ADDR_SB;
                    2:  return ADDR_SC;
                    3:  return ADDR_DIV;
                    4:  return ADDR_TAC;
                    5:  return ADDR_IF;
                    6:  return ADDR_LCDC;
                    7:  return ADDR_STAT;
                    8:  return ADDR_LY;
                    9:  return ADDR_DMA;
                    10: return ADDR_IE;
                    11: return ADDR_WRAM_LO;
                    12: return ADDR_WRAM_HI;
                    13: return ADDR_ECHO_LO;
                    14: return ADDR_ECHO_HI;
                    default: return ADDR_ROM_TOP;
                endcase
            end
        endcase
    endfunction

    task automatic offer_access(input logic [1:0] cmd_in, input logic [15:0] addr,
                                input logic [7:0] wdata, input logic [7:0] keys,
                                input logic done);
        logic [1:0] cmd;
        int         gap;
        @(negedge i_clk);
        if (burst_left == 0 && hold_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        cmd = sb.safe_command(cmd_in, addr, wdata, done);
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.address    <= addr;
        req_ch.write_data <= wdata;
        req_ch.keys       <= keys;
        req_ch.dma_done   <= done;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        sb.note_access(cmd, addr, wdata, keys, done);
    endtask

    initial begin
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  keys;
        logic        done;
        int          pick;
        int          tail;

        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_READ;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        req_ch.keys       = '0;
        req_ch.dma_done   = 1'b0;
        i_rst_n           = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        offer_access(CMD_LOAD,  ADDR_JOYP,      8'hFF, 8'h00, 1'b0);
        offer_access(CMD_LOAD,  ADDR_IF,        8'h00, 8'h00, 1'b0);
        offer_access(CMD_LOAD,  ADDR_SB,        8'h5A, 8'h00, 1'b0);
        offer_access(CMD_BOOT,  16'h0000,       8'h31, 8'h00, 1'b0);
        offer_access(CMD_BOOT,  16'h00FF,       8'hAB, 8'h00, 1'b0);
        offer_access(CMD_BOOT,  16'h0100,       8'h11, 8'h00, 1'b0);
        offer_access(CMD_READ,  16'h0000,       8'h00, 8'hFF, 1'b0);
        offer_access(CMD_READ,  16'h00FF,       8'h00, 8'h00, 1'b0);
        offer_access(CMD_WRITE, ADDR_ROM_TOP,   8'h00, 8'h00, 1'b0);
        offer_access(CMD_WRITE, ADDR_WRAM_LO,   8'h12, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_ECHO_LO,   8'h00, 8'h00, 1'b0);
        offer_access(CMD_WRITE, ADDR_ECHO_HI,   8'hFF, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_WRAM_HI,   8'h00, 8'h00, 1'b0);
        offer_access(CMD_WRITE, ADDR_JOYP,      8'h20, 8'hF0, 1'b0);
        offer_access(CMD_READ,  ADDR_IF,        8'h00, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_JOYP,      8'h00, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_LCDC,      8'h00, 8'h00, 1'b0);
        offer_access(CMD_WRITE, 16'hFF05,       8'h9C, 8'h00, 1'b0);
        offer_access(CMD_WRITE, ADDR_IE,        8'hA5, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_IE,        8'h00, 8'h00, 1'b0);
        offer_access(CMD_WRITE, ADDR_SC,        SERIAL_START, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_SC,        8'h00, 8'h00, 1'b0);
        offer_access(CMD_WRITE, ADDR_DMA,       8'hC0, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_WRAM_LO,   8'h00, 8'h00, 1'b0);
        offer_access(CMD_READ,  ADDR_WRAM_LO,   8'h00, 8'h00, 1'b1);

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 150) hold_left = 400;
            pick = $urandom_range(0, 99);
            keys = $urandom;
            data = $urandom;
            done = ($urandom_range(0, 5) == 0);
            if (i == RANDOM_ITEMS * 2 / 3) begin
                cmd  = CMD_WRITE;
                addr = ADDR_BOOT_OFF;
            end else if (pick < 35) begin
                cmd = CMD_READ;
                if (sb.recent_addrs.size() > 0 && $urandom_range(0, 2) != 0)
                    addr = sb.recent_addrs[$urandom_range(0, sb.recent_addrs.size() - 1)];
                else
                    addr = pick_addr();
            end else if (pick < 70) begin
                cmd  = CMD_WRITE;
                addr = pick_addr();
                if (addr == ADDR_SC && $urandom_range(0, 1) == 1) data = SERIAL_START;
            end else if (pick < 85) begin
                cmd  = CMD_LOAD;
                addr = pick_addr();
            end else if (pick < 93) begin
                cmd  = CMD_BOOT;
                addr = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, BOOT_BYTES - 1));
            end else begin
                cmd  = CMD_WRITE;
                addr = ADDR_DMA;
            end
            // keep the boot overlay until the planned unmap
            if (cmd == CMD_WRITE && addr == ADDR_BOOT_OFF && i < RANDOM_ITEMS * 2 / 3)
                addr = ADDR_BOOT_OFF + 16'd1;
            offer_access(cmd, addr, data, keys, done);
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        while (sb.owed_results.size() != 0) @(posedge i_clk);
        tail = 12;
        repeat (tail) @(posedge i_clk);
        if (sb.owed_results.size() != 0) begin
            $display("%0t %0d results never arrived", $time, sb.owed_results.size());
            sb.errors++;
        end

        $display("covered %0d reads (%0d accesses locked out), %0d writes, %0d loads, %0d boot loads",
                 sb.n_read, sb.n_locked, sb.n_write, sb.n_load, sb.n_boot);
        $display("%0d forwarded, %0d serial strobes, %0d dma starts, %0d joypad irqs, %0d checked",
                 sb.n_fwd, sb.n_serial, sb.n_dma, sb.n_joy_irq, sb.n_checked);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
